[rtl/lfc_pkg.sv]
package lfc_pkg;

	// Slot table geometry
	localparam int NUM_SLOTS = 5;
	localparam int MASK_BITS = 5;
	localparam int SLOT_SPAN = (NUM_SLOTS < MASK_BITS) ? NUM_SLOTS : MASK_BITS;
	localparam int SLOT_W    = 3;
	localparam int FROM_W    = SLOT_W + 1;

	// Field widths
	localparam int TIME_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_MASK  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONNECT_TO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_IVL  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESYNC_IVL = 2'd3;

	// Configuration reset values
	localparam logic [TIME_W-1:0] CONNECT_TO_RST = 32'd20000;
	localparam logic [TIME_W-1:0] RETRY_IVL_RST  = 32'd120000;
	localparam logic [TIME_W-1:0] RESYNC_IVL_RST = 32'd21600000;

	// Event kinds
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Reported mode codes
	localparam logic [1:0] MODE_CODE_CONN = 2'd0;
	localparam logic [1:0] MODE_CODE_STA  = 2'd1;
	localparam logic [1:0] MODE_CODE_AP   = 2'd2;

	// Controller mode, one-hot
	typedef enum logic [2:0] {
		MODE_CONN = 3'b001,
		MODE_STA  = 3'b010,
		MODE_AP   = 3'b100
	} mode_t;

	// One event as held in the input stage
	typedef struct packed {
		logic              opcode;
		logic [TIME_W-1:0] now_ms;
		logic              link_up;
	} event_t;

	// One result, packed lowest field in the lowest bits
	typedef struct packed {
		logic              cmd_sync_time;
		logic              cmd_announce;
		logic              cmd_start_ap;
		logic [SLOT_W-1:0] station_slot;
		logic              cmd_start_station;
		logic [1:0]        mode_now;
	} result_t;

	// Slot search result
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
	} slot_hit_t;

	// First configured slot at or above a start index
	function automatic slot_hit_t find_slot(input logic [MASK_BITS-1:0] mask,
		input logic [FROM_W-1:0] from);
		slot_hit_t hit;
		hit.found = 1'b0;
		hit.slot  = '0;
		for (int i = MASK_BITS - 1; i >= 0; i--) begin
			if (i >= int'(from) && i < SLOT_SPAN && mask[i]) begin
				hit.found = 1'b1;
				hit.slot  = SLOT_W'(i);
			end
		end
		return hit;
	endfunction

	function automatic logic [1:0] mode_code(input mode_t m);
		logic [1:0] code;
		case (m)
			MODE_CONN: code = MODE_CODE_CONN;
			MODE_STA:  code = MODE_CODE_STA;
			default:   code = MODE_CODE_AP;
		endcase
		return code;
	endfunction

endpackage

[rtl/link_failover_controller_top.sv]
// Link failover controller.
// Input stream (s_*): one transaction per start-up or poll event. tuser is the
// event kind (0 start-up, 1 poll tick); tdata carries now_ms and link_up.
// Output stream (m_*): exactly one result transaction per event, giving the
// mode after the event and the radio commands (start station with slot,
// start access point, restart announcement, request time sync).
// Configuration: cfg_we writes cfg_data into register cfg_index (0 slot mask,
// 1 connect timeout, 2 retry interval, 3 resync interval); write
// only while no event is in flight.
// Result path: the event passes the input register, then the decision logic
// into the result register. Throughput: one event per cycle while m_tready is high.
// Reset: mode goes to connecting, slot and timestamps clear, registers take
// their default values, both stream stages empty.
// Stall: when m_tready is low the result holds; one more event waits in the
// input register and s_tready then drops until the result is taken.
module link_failover_controller_top
	import lfc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// Event input
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] now_ms, [32] link_up, [39:33] zero
	input  logic                 s_tuser,   // [0] opcode
	// Result output
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // [1:0] mode_now, [2] cmd_start_station,
	                                        // [5:3] station_slot, [6] cmd_start_ap,
	                                        // [7] cmd_announce, [8] cmd_sync_time,
	                                        // [15:9] zero
);

	// Configuration registers
	logic [MASK_BITS-1:0] slot_mask_q;
	logic [TIME_W-1:0]    connect_to_q;
	logic [TIME_W-1:0]    retry_ivl_q;
	logic [TIME_W-1:0]    resync_ivl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_mask_q  <= '0;
			connect_to_q <= CONNECT_TO_RST;
			retry_ivl_q  <= RETRY_IVL_RST;
			resync_ivl_q <= RESYNC_IVL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLOT_MASK:  slot_mask_q  <= cfg_data[MASK_BITS-1:0];
				REG_CONNECT_TO: connect_to_q <= cfg_data[TIME_W-1:0];
				REG_RETRY_IVL:  retry_ivl_q  <= cfg_data[TIME_W-1:0];
				REG_RESYNC_IVL: resync_ivl_q <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage handshakes
	logic    valid_s1;
	event_t  ev_s1;
	logic    valid_s2;
	result_t res_s2;
	logic    advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ev_s1.opcode  <= s_tuser;
			ev_s1.now_ms  <= s_tdata[TIME_W-1:0];
			ev_s1.link_up <= s_tdata[TIME_W];
		end
	end

	// Controller state
	mode_t             mode_q,  mode_d;
	logic [SLOT_W-1:0] attempt_slot_q, attempt_slot_d;
	logic [TIME_W-1:0] attempt_start_q, attempt_start_d;
	logic [TIME_W-1:0] last_retry_q, last_retry_d;
	logic [TIME_W-1:0] last_sync_q, last_sync_d;
	result_t           res_d;

	slot_hit_t         hit_top;
	slot_hit_t         hit_next;
	logic [TIME_W-1:0] attempt_age;
	logic [TIME_W-1:0] sync_age;
	logic [TIME_W-1:0] retry_age;
	logic              join_en;
	logic [SLOT_W-1:0] join_slot;

	assign hit_top     = find_slot(slot_mask_q, '0);
	assign hit_next    = find_slot(slot_mask_q, FROM_W'(attempt_slot_q) + FROM_W'(1));
	assign attempt_age = ev_s1.now_ms - attempt_start_q;
	assign sync_age    = ev_s1.now_ms - last_sync_q;
	assign retry_age   = ev_s1.now_ms - last_retry_q;

	// Decision logic for one event
	always_comb begin
		mode_d          = mode_q;
		attempt_slot_d  = attempt_slot_q;
		attempt_start_d = attempt_start_q;
		last_retry_d    = last_retry_q;
		last_sync_d     = last_sync_q;
		join_en         = 1'b0;
		join_slot       = hit_top.slot;
		res_d           = '0;

		if (ev_s1.opcode == OP_START) begin
			if (!hit_top.found) begin
				mode_d             = MODE_AP;
				res_d.cmd_start_ap = 1'b1;
				res_d.cmd_announce = 1'b1;
			end else begin
				join_en = 1'b1;
			end
		end else begin
			case (mode_q)
				MODE_CONN: begin
					if (ev_s1.link_up) begin
						mode_d              = MODE_STA;
						res_d.cmd_announce  = 1'b1;
						res_d.cmd_sync_time = 1'b1;
						last_sync_d         = ev_s1.now_ms;
					end else if (attempt_age > connect_to_q) begin
						if (hit_next.found) begin
							join_en   = 1'b1;
							join_slot = hit_next.slot;
						end else begin
							mode_d             = MODE_AP;
							res_d.cmd_start_ap = 1'b1;
							res_d.cmd_announce = 1'b1;
							last_retry_d       = ev_s1.now_ms;
						end
					end
				end
				MODE_STA: begin
					if (!ev_s1.link_up) begin
						if (hit_top.found) begin
							join_en = 1'b1;
						end else begin
							mode_d             = MODE_AP;
							res_d.cmd_start_ap = 1'b1;
						end
					end else if (sync_age > resync_ivl_q) begin
						res_d.cmd_sync_time = 1'b1;
						last_sync_d         = ev_s1.now_ms;
					end
				end
				default: begin
					mode_d = MODE_AP;
					if (hit_top.found && retry_age > retry_ivl_q) begin
						last_retry_d = ev_s1.now_ms;
						join_en      = 1'b1;
					end
				end
			endcase
		end

		// Join a slot: start a new connection attempt
		if (join_en) begin
			mode_d                  = MODE_CONN;
			attempt_slot_d          = join_slot;
			attempt_start_d         = ev_s1.now_ms;
			res_d.cmd_start_station = 1'b1;
			res_d.station_slot      = join_slot;
		end

		res_d.mode_now = mode_code(mode_d);
	end

	// State update and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_CONN;
			attempt_slot_q  <= '0;
			attempt_start_q <= '0;
			last_retry_q    <= '0;
			last_sync_q     <= '0;
			valid_s2        <= 1'b0;
		end else begin
			if (advance) begin
				mode_q          <= mode_d;
				attempt_slot_q  <= attempt_slot_d;
				attempt_start_q <= attempt_start_d;
				last_retry_q    <= last_retry_d;
				last_sync_q     <= last_sync_d;
				valid_s2        <= 1'b1;
			end else if (m_tready) begin
				valid_s2        <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = M_TDATA_W'(res_s2);

endmodule
